// File: hw/rtl/cfp_pkg.sv
// Shared types, result codes and the CRC16 byte update for the frame parser.
// No dependencies; every other file of the block imports this package.
package cfp_pkg;

   // Result codes reported in the kind field.
   typedef enum logic [1:0] {
      KIND_DATA    = 2'd0,
      KIND_ACCEPT  = 2'd1,
      KIND_CRC_ERR = 2'd2
   } kind_type;

   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [15:0] CRC_INIT    = 16'h0000;
   localparam logic [7:0]  ID_KNOWN_LO = 8'h01;
   localparam logic [7:0]  ID_KNOWN_HI = 8'h05;

   // One result item as it travels from the parser core to the output register.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [7:0]  data_index;
      logic [7:0]  hdr_id;
      logic [7:0]  sequence_res;
      logic [7:0]  hdr_len;
      logic [15:0] rx_crc;
      logic [15:0] local_crc;
      logic        id_known;
   } result_type;

   // CRC16, MSB first, one byte folded in as eight shift-and-xor steps.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// File: hw/rtl/crc_checked_frame_parser.sv
// Top level of the CRC16-checked byte frame parser: input register, sync register,
// parser core and output register. Depends on cfp_pkg, cfp_parse_core, cfp_rsp_reg.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  req_rx_byte
//   rsp_      out        rsp_valid/rsp_stall  kind, data, header fields, CRCs, id_known
//   csr_      in         csr_valid/csr_ready  csr_sync_byte
//
// One item per cycle sustained while rsp_stall is low; a byte taken into the input
// register is parsed from there during the next cycle, and its result is loaded into
// the output register when the output side has room.
// That rate is set by the unrolled 8-bit CRC update in the core.
// Reset is synchronous and active high; the sync register resets to 0xAA.
// A stalled result holds the output register; the input register then fills and
// req_stall rises, and no item is lost.
module crc_checked_frame_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_data_index,
   output logic [7:0]  rsp_hdr_id,
   output logic [7:0]  rsp_sequence_res,
   output logic [7:0]  rsp_hdr_len,
   output logic [15:0] rsp_rx_crc,
   output logic [15:0] rsp_local_crc,
   output logic        rsp_id_known,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_sync_byte
);
   import cfp_pkg::*;

   localparam logic [7:0] SYNC_RESET = 8'hAA;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic [7:0] sync_byte_ff;
   logic       req_accept;
   logic       proc_fire;
   logic       slot_free;
   logic       res_valid;
   result_type res;
   result_type rsp;

   // The input register moves on whenever the output side has room.
   assign proc_fire  = in_valid_ff && slot_free;
   assign req_stall  = in_valid_ff && !slot_free;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (proc_fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         sync_byte_ff <= SYNC_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_valid && csr_ready) begin
            sync_byte_ff <= csr_sync_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   cfp_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (proc_fire),
      .rx_byte   (in_byte_ff),
      .sync_byte (sync_byte_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   cfp_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .fire      (proc_fire),
      .res_valid (res_valid),
      .res       (res),
      .rsp_stall (rsp_stall),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   // Result fields onto their own ports.
   assign rsp_kind         = rsp.kind;
   assign rsp_data_byte    = rsp.data_byte;
   assign rsp_data_index   = rsp.data_index;
   assign rsp_hdr_id       = rsp.hdr_id;
   assign rsp_sequence_res = rsp.sequence_res;
   assign rsp_hdr_len      = rsp.hdr_len;
   assign rsp_rx_crc       = rsp.rx_crc;
   assign rsp_local_crc    = rsp.local_crc;
   assign rsp_id_known     = rsp.id_known;

endmodule

// File: hw/rtl/cfp_parse_core.sv
// Frame parser state machine: sync hunt, header, payload and CRC phases.
// Depends on cfp_pkg for the result struct, result codes and CRC update.
module cfp_parse_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [7:0]           rx_byte,
   input  logic [7:0]           sync_byte,
   output logic                 res_valid,
   output cfp_pkg::result_type  res
);
   import cfp_pkg::*;

   typedef enum logic [1:0] {
      PH_HUNT   = 2'd0,
      PH_HEADER = 2'd1,
      PH_DATA   = 2'd2,
      PH_CRC    = 2'd3
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  header_count_ff, header_count_in;
   logic [7:0]  frame_id_ff, frame_id_in;
   logic [7:0]  frame_seq_ff, frame_seq_in;
   logic [7:0]  frame_len_ff, frame_len_in;
   logic [7:0]  data_count_ff, data_count_in;
   logic [15:0] crc_acc_ff, crc_acc_in;
   logic [7:0]  crc_high_ff, crc_high_in;
   logic        crc_count_ff, crc_count_in;

   logic [15:0] crc_next;
   logic [15:0] rx_crc_full;
   logic [7:0]  data_count_inc;

   assign crc_next       = crc_feed(crc_acc_ff, rx_byte);
   assign rx_crc_full    = {crc_high_ff, rx_byte};
   assign data_count_inc = data_count_ff + 8'd1;

   // Next state and the result for the byte in the input register.
   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      frame_id_in     = frame_id_ff;
      frame_seq_in    = frame_seq_ff;
      frame_len_in    = frame_len_ff;
      data_count_in   = data_count_ff;
      crc_acc_in      = crc_acc_ff;
      crc_high_in     = crc_high_ff;
      crc_count_in    = crc_count_ff;

      res_valid        = 1'b0;
      res.kind         = KIND_DATA;
      res.data_byte    = 8'h00;
      res.data_index   = 8'h00;
      res.hdr_id       = frame_id_ff;
      res.sequence_res = frame_seq_ff;
      res.hdr_len      = frame_len_ff;
      res.rx_crc       = 16'h0000;
      res.local_crc    = 16'h0000;
      res.id_known     = (frame_id_ff >= ID_KNOWN_LO) && (frame_id_ff <= ID_KNOWN_HI);

      case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == sync_byte) begin
               crc_acc_in      = crc_feed(CRC_INIT, rx_byte);
               header_count_in = 2'd0;
               phase_in        = PH_HEADER;
            end
         end
         PH_HEADER: begin
            crc_acc_in = crc_next;
            case (header_count_ff)
               2'd0: begin
                  frame_id_in     = rx_byte;
                  header_count_in = 2'd1;
               end
               2'd1: begin
                  frame_seq_in    = rx_byte;
                  header_count_in = 2'd2;
               end
               default: begin
                  frame_len_in    = rx_byte;
                  header_count_in = 2'd0;
                  data_count_in   = 8'd0;
                  crc_count_in    = 1'b0;
                  phase_in        = (rx_byte == 8'd0) ? PH_CRC : PH_DATA;
               end
            endcase
         end
         PH_DATA: begin
            crc_acc_in     = crc_next;
            res_valid      = 1'b1;
            res.kind       = KIND_DATA;
            res.data_byte  = rx_byte;
            res.data_index = data_count_ff;
            data_count_in  = data_count_inc;
            if (data_count_inc == frame_len_ff) begin
               crc_count_in = 1'b0;
               phase_in     = PH_CRC;
            end
         end
         default: begin
            if (!crc_count_ff) begin
               crc_high_in  = rx_byte;
               crc_count_in = 1'b1;
            end else begin
               res_valid     = 1'b1;
               res.kind      = (rx_crc_full == crc_acc_ff) ? KIND_ACCEPT : KIND_CRC_ERR;
               res.rx_crc    = rx_crc_full;
               res.local_crc = crc_acc_ff;
               crc_count_in  = 1'b0;
               phase_in      = PH_HUNT;
            end
         end
      endcase
   end

   // State registers advance only when the byte is consumed.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         header_count_ff <= 2'd0;
         data_count_ff   <= 8'd0;
         crc_count_ff    <= 1'b0;
      end else if (fire) begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         data_count_ff   <= data_count_in;
         crc_count_ff    <= crc_count_in;
      end
   end

   // Header fields and CRC registers are always loaded before they are used.
   always_ff @(posedge clock) begin
      if (fire) begin
         frame_id_ff  <= frame_id_in;
         frame_seq_ff <= frame_seq_in;
         frame_len_ff <= frame_len_in;
         crc_acc_ff   <= crc_acc_in;
         crc_high_ff  <= crc_high_in;
      end
   end

endmodule

// File: hw/rtl/cfp_rsp_reg.sv
// Output register for result items, holding a result while the sink stalls.
// Depends on cfp_pkg for the result struct.
module cfp_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic                 res_valid,
   input  cfp_pkg::result_type  res,
   input  logic                 rsp_stall,
   output logic                 slot_free,
   output logic                 rsp_valid,
   output cfp_pkg::result_type  rsp
);
   import cfp_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   // The register can take a new result when empty or emptying this cycle.
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (fire) begin
         rsp_valid_in = res_valid;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: sim/crc_checked_frame_parser_tb.sv
// Self-checking testbench for the CRC16-checked byte frame parser.
// Depends on cfp_pkg for the result layout and kind codes, and on the parser top level.
module crc_checked_frame_parser_tb;
   import cfp_pkg::*;

   localparam int RANDOM_ITEMS = 440;
   localparam int STEADY_ITEMS = 100;
   localparam int HOLD_CYCLES  = 90;
   localparam int DRAIN_LIMIT  = 3000;
   localparam int REPORT_LIMIT = 10;

   // Parser phases as tracked by the predictor.
   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HEADER,
      PH_PAYLOAD,
      PH_CHECKSUM
   } parse_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [7:0]  rsp_data_index;
   logic [7:0]  rsp_hdr_id;
   logic [7:0]  rsp_sequence_res;
   logic [7:0]  rsp_hdr_len;
   logic [15:0] rsp_rx_crc;
   logic [15:0] rsp_local_crc;
   logic        rsp_id_known;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_sync_byte = 8'h00;

   // Predicted parser state and the sync register as last written.
   logic [7:0]      sync_copy = 8'hAA;
   parse_phase_type phase_q = PH_HUNT;
   logic [1:0]      hdr_count = 2'd0;
   logic [7:0]      frame_id = 8'h00;
   logic [7:0]      frame_seq = 8'h00;
   logic [7:0]      frame_len = 8'h00;
   logic [7:0]      payload_count = 8'h00;
   logic [15:0]     crc_run = 16'h0000;
   logic [7:0]      crc_hi_byte = 8'h00;
   logic            crc_half = 1'b0;

   // Frame events predicted but not yet seen on the result port.
   result_type frame_events[$];

   // Traffic shaping controls shared by the sender and the receiver.
   bit tx_idle_on = 1'b1;
   bit rx_idle_on = 1'b1;
   bit hold_request = 1'b0;

   int bytes_sent = 0;
   int mismatch_count = 0;
   int payload_seen = 0;
   int accept_seen = 0;
   int crc_err_seen = 0;

   crc_checked_frame_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_data_index   (rsp_data_index),
      .rsp_hdr_id       (rsp_hdr_id),
      .rsp_sequence_res (rsp_sequence_res),
      .rsp_hdr_len      (rsp_hdr_len),
      .rsp_rx_crc       (rsp_rx_crc),
      .rsp_local_crc    (rsp_local_crc),
      .rsp_id_known     (rsp_id_known),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_sync_byte    (csr_sync_byte)
   );

   always #4 clock = ~clock;

   // Bitwise CRC16 over one byte, MSB first, polynomial 0x1021.
   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c  = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
      end
      return c;
   endfunction

   // Advances the predicted parser by one received byte and queues any event it causes.
   function automatic void parse_rx_byte(input logic [7:0] b);
      result_type ev;
      logic [15:0] got_crc;
      bit          produced;
      ev       = '0;
      produced = 1'b0;
      case (phase_q)
         PH_HUNT: begin
            if (b == sync_copy) begin
               crc_run   = crc16_step(16'h0000, b);
               hdr_count = 2'd0;
               phase_q   = PH_HEADER;
            end
         end
         PH_HEADER: begin
            crc_run = crc16_step(crc_run, b);
            if (hdr_count == 2'd0) begin
               frame_id  = b;
               hdr_count = 2'd1;
            end else if (hdr_count == 2'd1) begin
               frame_seq = b;
               hdr_count = 2'd2;
            end else begin
               frame_len     = b;
               hdr_count     = 2'd0;
               payload_count = 8'h00;
               crc_half      = 1'b0;
               phase_q       = (b == 8'h00) ? PH_CHECKSUM : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            crc_run       = crc16_step(crc_run, b);
            produced      = 1'b1;
            ev.kind       = KIND_DATA;
            ev.data_byte  = b;
            ev.data_index = payload_count;
            payload_count = payload_count + 8'd1;
            if (payload_count == frame_len) begin
               crc_half = 1'b0;
               phase_q  = PH_CHECKSUM;
            end
         end
         default: begin
            if (!crc_half) begin
               crc_hi_byte = b;
               crc_half    = 1'b1;
            end else begin
               got_crc      = {crc_hi_byte, b};
               produced     = 1'b1;
               ev.kind      = (got_crc == crc_run) ? KIND_ACCEPT : KIND_CRC_ERR;
               ev.rx_crc    = got_crc;
               ev.local_crc = crc_run;
               crc_half     = 1'b0;
               phase_q      = PH_HUNT;
            end
         end
      endcase
      // Payload bytes and frame ends both carry the current header.
      if (produced) begin
         ev.hdr_id       = frame_id;
         ev.sequence_res = frame_seq;
         ev.hdr_len      = frame_len;
         ev.id_known     = (frame_id >= 8'h01) && (frame_id <= 8'h05);
         frame_events.push_back(ev);
      end
   endfunction

   // Sends one byte, with an optional idle gap first; the prediction is made on acceptance.
   task automatic send_byte(input logic [7:0] b);
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      predict_and_queue(b);
   endtask

   // Wraps the phase update and pushes an event when the byte produces one.
   task automatic predict_and_queue(input logic [7:0] b);
      parse_rx_byte(b);
   endtask

   // Sends a whole frame with the current sync byte; the CRC can be spoiled on purpose.
   task automatic send_frame(input logic [7:0] id, input logic [7:0] seq_no,
                             input logic [7:0] len, input logic [7:0] first_payload,
                             input bit corrupt);
      logic [15:0] crc;
      logic [7:0]  b;
      crc = crc16_step(16'h0000, sync_copy);
      send_byte(sync_copy);
      crc = crc16_step(crc, id);
      send_byte(id);
      crc = crc16_step(crc, seq_no);
      send_byte(seq_no);
      crc = crc16_step(crc, len);
      send_byte(len);
      for (int i = 0; i < len; i++) begin
         if (i == 0) begin
            b = first_payload;
         end else if ($urandom_range(0, 7) == 0) begin
            b = sync_copy;
         end else begin
            b = 8'($urandom);
         end
         crc = crc16_step(crc, b);
         send_byte(b);
      end
      if (corrupt) begin
         crc = crc ^ 16'($urandom_range(1, 65535));
      end
      send_byte(crc[15:8]);
      send_byte(crc[7:0]);
   endtask

   // Stops sending and waits, with a bound, until every predicted event has come out.
   task automatic drain_results;
      req_valid <= 1'b0;
      for (int n = 0; n < DRAIN_LIMIT && frame_events.size() != 0; n++) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);
   endtask

   // Writes the sync register; only called while the parser is idle.
   task automatic write_sync(input logic [7:0] value);
      csr_valid     <= 1'b1;
      csr_sync_byte <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sync_copy  = value;
   endtask

   // Bytes that are not the sync value are dropped while hunting.
   task automatic test_hunt_noise;
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h55);
   endtask

   // A frame with no payload goes straight from the header to the CRC.
   task automatic test_empty_frame;
      send_frame(8'h01, 8'hFF, 8'h00, 8'h00, 1'b0);
   endtask

   // A spoiled CRC, an unknown id and the sync value inside the payload.
   task automatic test_crc_error;
      send_frame(8'h06, 8'h00, 8'h02, sync_copy, 1'b1);
   endtask

   // The highest known id with a one-byte payload.
   task automatic test_known_id_edge;
      send_frame(8'h05, 8'h80, 8'h01, 8'h00, 1'b0);
   endtask

   // Four sync settings, extremes included, with a rejected byte ahead of each frame.
   task automatic test_sync_register;
      logic [7:0] values [4];
      values[0] = 8'h00;
      values[1] = 8'hFF;
      values[2] = 8'($urandom_range(1, 254));
      values[3] = 8'hAA;
      foreach (values[k]) begin
         drain_results();
         write_sync(values[k]);
         send_byte(~values[k]);
         send_frame(8'($urandom), 8'($urandom), 8'($urandom_range(0, 6)), 8'($urandom),
                    1'($urandom_range(0, 1)));
      end
   endtask

   // The receiver holds off for a long stretch so the parser backs up into its input.
   task automatic test_output_backpressure;
      drain_results();
      hold_request = 1'b1;
      send_frame(8'h03, 8'h11, 8'd48, 8'hFF, 1'b0);
      // The sender then waits for everything to come out.
      drain_results();
   endtask

   // Mostly well-formed frames with random content, plus noise and cut-off frames.
   task automatic test_random_frames;
      int start_count;
      int pick;
      bit big_done;
      logic [7:0] id;
      logic [7:0] len;
      start_count = bytes_sent;
      big_done    = 1'b0;
      while (bytes_sent - start_count < RANDOM_ITEMS) begin
         // Idling comes and goes in stretches.
         tx_idle_on = ((bytes_sent / 90) % 3) != 2;
         rx_idle_on = ((bytes_sent / 70) % 3) != 1;
         pick = $urandom_range(0, 99);
         id   = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
         if (!big_done && bytes_sent - start_count > RANDOM_ITEMS / 3) begin
            // One frame at the largest length reaches the last payload index.
            send_frame(id, 8'($urandom), 8'hFF, 8'($urandom), 1'($urandom_range(0, 1)));
            big_done = 1'b1;
         end else if (pick < 70) begin
            len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 60))
                                               : 8'($urandom_range(0, 12));
            send_frame(id, 8'($urandom), len, 8'($urandom), $urandom_range(0, 4) == 0);
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
         end else if (pick < 96) begin
            // A frame cut short; later bytes are parsed as whatever phase it left.
            send_byte(sync_copy);
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 15)));
         end else begin
            drain_results();
         end
      end
   endtask

   // Back-to-back frames with no idling on either side.
   task automatic test_steady_stream;
      int start_count;
      start_count = bytes_sent;
      tx_idle_on  = 1'b0;
      rx_idle_on  = 1'b0;
      while (bytes_sent - start_count < STEADY_ITEMS) begin
         send_frame(8'($urandom_range(0, 7)), 8'($urandom), 8'($urandom_range(0, 10)),
                    8'($urandom), $urandom_range(0, 3) == 0);
      end
   endtask

   // Receiver: random stall bursts, and one long hold when asked for.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall   <= 1'b1;
            for (int n = 0; n < HOLD_CYCLES; n++) begin
               @(posedge clock);
            end
            rsp_stall <= 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compares each accepted result with the oldest predicted event.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind         = kind_type'(rsp_kind);
         got.data_byte    = rsp_data_byte;
         got.data_index   = rsp_data_index;
         got.hdr_id       = rsp_hdr_id;
         got.sequence_res = rsp_sequence_res;
         got.hdr_len      = rsp_hdr_len;
         got.rx_crc       = rsp_rx_crc;
         got.local_crc    = rsp_local_crc;
         got.id_known     = rsp_id_known;
         if (frame_events.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("Unexpected result at %0t: kind %0d", $time, rsp_kind);
            end
         end else begin
            want = frame_events.pop_front();
            if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                got.data_index !== want.data_index || got.hdr_id !== want.hdr_id ||
                got.sequence_res !== want.sequence_res ||
                got.hdr_len !== want.hdr_len || got.rx_crc !== want.rx_crc ||
                got.local_crc !== want.local_crc || got.id_known !== want.id_known) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("Mismatch at %0t (expected/actual): kind %0d/%0d byte %h/%h",
                           $time, want.kind, got.kind, want.data_byte, got.data_byte);
                  $display("   index %0d/%0d id %h/%h seq %h/%h len %0d/%0d",
                           want.data_index, got.data_index, want.hdr_id,
                           got.hdr_id, want.sequence_res, got.sequence_res,
                           want.hdr_len, got.hdr_len);
                  $display("   rx_crc %h/%h local_crc %h/%h id_known %b/%b",
                           want.rx_crc, got.rx_crc, want.local_crc, got.local_crc,
                           want.id_known, got.id_known);
               end
            end
            if (want.kind == KIND_DATA) begin
               payload_seen++;
            end else if (want.kind == KIND_ACCEPT) begin
               accept_seen++;
            end else begin
               crc_err_seen++;
            end
         end
      end
   end

   // Test sequence and end of run.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_hunt_noise();
      test_empty_frame();
      test_crc_error();
      test_known_id_edge();
      test_sync_register();
      test_output_backpressure();
      test_random_frames();
      test_steady_stream();
      drain_results();
      if (frame_events.size() != 0) begin
         $display("%0d predicted results never arrived", frame_events.size());
      end
      $display("Sent %0d bytes; checked %0d payload bytes, %0d good and %0d bad-CRC frames,",
               bytes_sent, payload_seen, accept_seen, crc_err_seen);
      $display("with sync values 00, FF, AA and one random, stalls, a long hold and pauses.");
      if (mismatch_count == 0 && frame_events.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: crc_checked_frame_parser.f
hw/rtl/cfp_pkg.sv
hw/rtl/cfp_parse_core.sv
hw/rtl/cfp_rsp_reg.sv
hw/rtl/crc_checked_frame_parser.sv
sim/crc_checked_frame_parser_tb.sv
